>>> hw/rtl/float_scale_by_power_of_ten_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the power-of-ten float scaler
// Shared concurrent assertion forms, clocked and gated by the active-low reset.
// ---------------------------------------------------------------------------
`ifndef FLOAT_SCALE_BY_POWER_OF_TEN_ASSERT_SVH
`define FLOAT_SCALE_BY_POWER_OF_TEN_ASSERT_SVH

// antecedent and consequent checked at the same edge
`define FSPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fspt check failed");

// consequent checked at the edge after the antecedent
`define FSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fspt check failed");

`endif

>>> hw/rtl/fspt_pkg.sv
// ---------------------------------------------------------------------------
// fspt_pkg
// Types and constants for the power-of-ten float scaler.
// ---------------------------------------------------------------------------
`default_nettype none

package fspt_pkg;

    // mantissa is unsigned Q0.31 with bit 30 as the leading one
    typedef logic [30:0]        t_mant;
    // partial remainder of the fraction division, always below the half divisor
    typedef logic [29:0]        t_rem;
    // working binary exponent, spans -160..130
    typedef logic signed [9:0]  t_expo;

    localparam t_mant MUL_DIVISOR = 31'h6666_6666;   // 0.8
    localparam t_mant DIV_DIVISOR = 31'h5000_0000;   // 0.625
    localparam t_rem  MUL_DEN     = 30'h3333_3333;   // half of 0.8
    localparam t_rem  DIV_DEN     = 30'h2800_0000;   // half of 0.625

    localparam t_expo EXPO_BIAS_IN   = 10'sd126;
    localparam t_expo EXPO_BIAS_OUT  = 10'sd126;
    localparam t_expo EXPO_OVF_LIMIT = 10'sd128;
    localparam t_expo EXPO_OVF       = 10'sd129;
    localparam t_expo EXPO_FLOOR     = -10'sd160;
    localparam t_expo EXPO_DENORM    = -10'sd126;

    localparam logic [4:0] DIV_LAST     = 5'd30;   // 31 quotient bits
    localparam logic [1:0] MUL_ADJ_LAST = 2'd2;    // exponent +3 per multiply
    localparam logic [1:0] DIV_ADJ_LAST = 2'd3;    // exponent -4 per divide

endpackage

`default_nettype wire

>>> hw/rtl/float_scale_by_power_of_ten.sv
// ---------------------------------------------------------------------------
// float_scale_by_power_of_ten
// Scales a single-precision bit pattern by ten to a signed power.
// ---------------------------------------------------------------------------
// Usage:
// - Input channel: i_valid / o_stall with i_value_bits and i_tens_exponent.
//   A word is taken when i_valid is high and o_stall is low; o_stall stays
//   high until the word's result has been loaded into the output register.
// - Output channel: o_valid / i_stall with o_result_bits. The result holds
//   in the output register while i_stall is high, and a new input word may
//   be taken while it waits there.
// - Each decimal step runs on one shared compare/subtract unit: a normalize
//   phase, a restoring division of 31 quotient bits, then an exponent
//   adjustment of +3 (multiply) or -4 (divide).
// - After division steps, a denormal shift moves one bit per cycle, up to 35 bits.
// - A zero exponent skips the decimal steps and goes straight to packing.
//   One word at a time.
// - Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending result.
// ---------------------------------------------------------------------------
`default_nettype none

module float_scale_by_power_of_ten
    import fspt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_value_bits,
    input  logic signed [7:0]  i_tens_exponent,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_result_bits
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_ADJ,
        S_UFLOW,
        S_PACK
    } t_state;

    t_state      r_state, n_state;
    t_mant       r_mant, n_mant;
    t_rem        r_rem, n_rem;
    t_expo       r_expo, n_expo;
    logic        r_neg, n_neg;
    logic        r_mul, n_mul;
    logic [7:0]  r_steps, n_steps;
    logic [4:0]  r_bit, n_bit;
    logic [1:0]  r_adj, n_adj;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_result, n_result;

    // shared compare/subtract unit
    t_mant       w_cmp_a, w_cmp_b;
    logic [31:0] w_diff;
    logic        w_ge;

    logic [7:0]  w_tens_mag;
    logic [25:0] w_round_sum;
    logic [24:0] w_round;
    t_expo       w_exp_sum;
    logic [31:0] w_packed;
    logic        w_adj_last;

    assign w_tens_mag = i_tens_exponent[7] ? (8'd0 - $unsigned(i_tens_exponent))
                                           : $unsigned(i_tens_exponent);

    always_comb begin
        if (r_state == S_DIV) begin
            w_cmp_a = {r_rem, 1'b0};
            w_cmp_b = {1'b0, (r_mul ? MUL_DEN : DIV_DEN)};
        end else begin
            w_cmp_a = r_mant;
            w_cmp_b = r_mul ? MUL_DIVISOR : DIV_DIVISOR;
        end
    end

    assign w_diff = {1'b0, w_cmp_a} - {1'b0, w_cmp_b};
    assign w_ge   = ~w_diff[31];

    // round: keep 25 bits, add one, drop one; a carry lands on exponent bit 1
    assign w_round_sum = {1'b0, r_mant[30:6]} + 26'd1;
    assign w_round     = w_round_sum[25:1];
    assign w_exp_sum   = r_expo + EXPO_BIAS_OUT;
    assign w_packed    = {r_neg,
                          w_exp_sum[7:0] | {6'd0, w_round[24], 1'b0},
                          w_round[22:0]};

    assign w_adj_last = r_mul ? (r_adj == MUL_ADJ_LAST) : (r_adj == DIV_ADJ_LAST);

    always_comb begin
        n_state     = r_state;
        n_mant      = r_mant;
        n_rem       = r_rem;
        n_expo      = r_expo;
        n_neg       = r_neg;
        n_mul       = r_mul;
        n_steps     = r_steps;
        n_bit       = r_bit;
        n_adj       = r_adj;
        n_result    = r_result;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value_bits[31];
                    n_expo  = t_expo'({2'b00, i_value_bits[30:23]}) - EXPO_BIAS_IN;
                    n_mant  = {1'b1, i_value_bits[22:0], 7'd0};
                    n_mul   = ~i_tens_exponent[7];
                    n_steps = w_tens_mag;
                    n_state = (w_tens_mag == 8'd0) ? S_PACK : S_NORM;
                end
            end
            S_NORM: begin
                // halve until below the divisor, then seed the remainder
                if (w_ge) begin
                    n_mant = r_mant >> 1;
                    n_expo = r_expo + 10'sd1;
                end else begin
                    n_rem   = r_mant[30:1];
                    n_bit   = 5'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // quotient bits shift into the mantissa register
                n_rem  = w_ge ? w_diff[29:0] : w_cmp_a[29:0];
                n_mant = {r_mant[29:0], w_ge};
                if (r_bit == DIV_LAST) begin
                    n_adj   = 2'd0;
                    n_state = S_ADJ;
                end else begin
                    n_bit = r_bit + 5'd1;
                end
            end
            S_ADJ: begin
                if (r_mul) begin
                    if (r_expo < EXPO_OVF_LIMIT) begin
                        n_expo = r_expo + 10'sd1;
                    end else begin
                        n_expo = EXPO_OVF;
                        n_mant = '0;
                    end
                end else if (r_expo > EXPO_FLOOR) begin
                    n_expo = r_expo - 10'sd1;
                end
                if (w_adj_last) begin
                    n_steps = r_steps - 8'd1;
                    if (r_steps == 8'd1) begin
                        n_state = r_mul ? S_PACK : S_UFLOW;
                    end else begin
                        n_state = S_NORM;
                    end
                end else begin
                    n_adj = r_adj + 2'd1;
                end
            end
            S_UFLOW: begin
                // shift one bit a cycle; the last shift leaves the exponent at -126
                if (r_expo <= EXPO_DENORM) begin
                    n_mant = r_mant >> 1;
                    if (r_expo == EXPO_DENORM) begin
                        n_state = S_PACK;
                    end else begin
                        n_expo = r_expo + 10'sd1;
                    end
                end else begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_result    = w_packed;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mant   <= n_mant;
        r_rem    <= n_rem;
        r_expo   <= n_expo;
        r_neg    <= n_neg;
        r_mul    <= n_mul;
        r_steps  <= n_steps;
        r_bit    <= n_bit;
        r_adj    <= n_adj;
        r_result <= n_result;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_result_bits = r_result;

endmodule

`default_nettype wire

>>> hw/rtl/fspt_checker.sv
// ---------------------------------------------------------------------------
// fspt_checker
// Port-level checks for the power-of-ten float scaler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "float_scale_by_power_of_ten_assert.svh"

module fspt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_result_bits
);

    // a stalled result word stays and holds its value
    `FSPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `FSPT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_result_bits))

    // a taken input word sets the block busy
    `FSPT_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a new result appears only at the end of a busy period
    `FSPT_ASSERT_SAME(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

endmodule

bind float_scale_by_power_of_ten fspt_checker u_fspt_checker (.*);

`default_nettype wire
